// ----- sv/mf3s_pkg.sv -----
package mf3s_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LINES = 3;
    localparam int PIX_W = 8;
    localparam int ROW_W = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 13;
    localparam int MODE_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W_W-1:0] WIDTH_RST = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(2);

    localparam logic ACT_PIXEL = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ZERO = 2'd0,
        MODE_COPY = 2'd1,
        MODE_PAD  = 2'd2
    } mode_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [1:0] slot_t;

    typedef struct packed {
        logic action;
        pix_t pixel_value;
    } pix_in_t;

    typedef struct packed {
        pix_t median_value;
        logic frame_end;
    } pix_out_t;

    typedef struct packed {
        pix_t lo;
        pix_t mi;
        pix_t hi;
    } trio_t;

    // Control that travels with one request from the line buffer read to the tap stage.
    typedef struct packed {
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             border;
        mode_t            mode;
        logic             frame_end;
        logic [LINES-1:0] hit_mid;
        logic [LINES-1:0] hit_right;
        pix_t             pix;
        slot_t            slot;
    } tap_ctl_t;

    function automatic slot_t slot_inc(slot_t s);
        slot_t r;
        r = (s == slot_t'(LINES - 1)) ? slot_t'(0) : s + slot_t'(1);
        return r;
    endfunction

    function automatic slot_t slot_dec(slot_t s);
        slot_t r;
        r = (s == slot_t'(0)) ? slot_t'(LINES - 1) : s - slot_t'(1);
        return r;
    endfunction

    function automatic trio_t sort3(pix_t a, pix_t b, pix_t c);
        pix_t x;
        pix_t y;
        trio_t r;
        x = (a > b) ? b : a;
        y = (a > b) ? a : b;
        if (c < x)
        begin
            r.lo = c;
            r.mi = x;
            r.hi = y;
        end
        else if (c < y)
        begin
            r.lo = x;
            r.mi = c;
            r.hi = y;
        end
        else
        begin
            r.lo = x;
            r.mi = y;
            r.hi = c;
        end
        return r;
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        trio_t t;
        t = sort3(a, b, c);
        return t.mi;
    endfunction

    function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

// ----- sv/mf3s_ram.sv -----
module mf3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] data_a_reg;
    logic [WIDTH-1:0] data_b_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem_reg[rd_addr_a];
            data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = data_a_reg;
    assign rd_data_b = data_b_reg;

endmodule

// ----- sv/median_filter_3x3_stream.sv -----
// A result passes the tap, sort and output registers after the request that completes its
// window, which is the pixel one row and one column further on or, once the frame is in, any
// request. Throughput: one request per cycle unless stalled; each pixel costs one write and
// each result two reads of the three line RAMs, which have separate ports and so never limit
// the rate. Reset clears all counters and restores the default frame setup; the line RAMs are
// not cleared, since no position is read before it has been written in the current frame.
module median_filter_3x3_stream #(
    parameter int MAX_WIDTH = mf3s_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  mf3s_pkg::pix_in_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output mf3s_pkg::pix_out_t                 out_data,
    input  logic                               cfg_write,
    input  logic [mf3s_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3s_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import mf3s_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int GAP_W = $clog2(MAX_WIDTH + 2);
    localparam int WIDTH_START = (int'(WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RST);

    logic [CFG_W_W-1:0] cfg_width_reg;
    logic [CFG_H_W-1:0] cfg_height_reg;
    logic [MODE_W-1:0]  cfg_mode_reg;

    logic [WID_W-1:0] act_w_reg;
    logic [ROW_W-1:0] act_h_reg;
    mode_t            act_mode_reg;

    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] in_col_next;
    logic [ROW_W-1:0] in_row_reg;
    logic [ROW_W-1:0] in_row_next;
    slot_t            in_slot_reg;
    slot_t            in_slot_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    slot_t            out_slot_reg;
    slot_t            out_slot_next;
    logic [GAP_W-1:0] gap_reg;
    logic [GAP_W-1:0] gap_next;

    logic [WID_W-1:0] cfg_w_clamp;
    logic [ROW_W-1:0] cfg_h_clamp;
    mode_t            cfg_mode_clamp;
    logic [WID_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    mode_t            eff_mode;

    logic             start;
    logic             accept;
    logic             is_pix;
    logic             in_done;
    logic [WID_W-1:0] in_col_inc;
    logic             in_wrap;
    logic [ROW_W-1:0] in_row_inc;
    logic             last_pix;
    logic             gap_full;
    logic             emit;
    logic [WID_W-1:0] out_col_inc;
    logic             out_wrap;
    logic [ROW_W-1:0] out_row_inc;
    logic             frame_done;
    logic [LINES-1:0] row_hit;
    logic             col_hit_mid;
    logic             col_hit_right;
    tap_ctl_t         ctl_next;

    logic             s1_valid_reg;
    tap_ctl_t         s1_ctl_reg;
    logic             s2_valid_reg;
    trio_t [LINES-1:0] s2_trio_reg;
    pix_t             s2_center_reg;
    logic             s2_border_reg;
    mode_t            s2_mode_reg;
    logic             s2_end_reg;
    trio_t            prev_trio_reg;
    logic             out_valid_reg;
    pix_out_t         out_data_reg;

    logic             out_free;
    logic             s2_ready;
    logic             s1_ready;
    logic             s1_move;

    pix_t             rd_a [LINES];
    pix_t             rd_b [LINES];
    slot_t            row_slot [LINES];
    logic [LINES-1:0] row_ok;
    pix_t             mid_tap [LINES];
    pix_t             right_tap [LINES];
    trio_t            left_trio;
    trio_t            mid_trio;
    trio_t            right_trio;
    pix_t             median;
    pix_t             result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= WIDTH_RST;
            cfg_height_reg <= HEIGHT_RST;
            cfg_mode_reg   <= MODE_ZERO;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_width_reg  <= cfg_data[CFG_W_W-1:0];
                CFG_HEIGHT: cfg_height_reg <= cfg_data[CFG_H_W-1:0];
                CFG_MODE:   cfg_mode_reg   <= cfg_data[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_width_reg == '0)
            cfg_w_clamp = WID_W'(1);
        else if (int'(cfg_width_reg) > MAX_WIDTH)
            cfg_w_clamp = WID_W'(MAX_WIDTH);
        else
            cfg_w_clamp = WID_W'(cfg_width_reg);

        if (cfg_height_reg == '0)
            cfg_h_clamp = ROW_W'(1);
        else if (cfg_height_reg > ROW_W'(MAX_HEIGHT))
            cfg_h_clamp = ROW_W'(MAX_HEIGHT);
        else
            cfg_h_clamp = cfg_height_reg;

        unique case (cfg_mode_reg)
            MODE_COPY: cfg_mode_clamp = MODE_COPY;
            MODE_PAD:  cfg_mode_clamp = MODE_PAD;
            default:   cfg_mode_clamp = MODE_ZERO;
        endcase
    end

    // Pipeline flow control.
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    // Position tracking and the decision whether a request produces a result.
    always_comb
    begin
        start = (in_row_reg == '0) && (in_col_reg == '0) &&
                (out_row_reg == '0) && (out_col_reg == '0);
        eff_w    = start ? cfg_w_clamp : act_w_reg;
        eff_h    = start ? cfg_h_clamp : act_h_reg;
        eff_mode = start ? cfg_mode_clamp : act_mode_reg;

        in_done = !(in_row_reg < eff_h);
        is_pix  = (in_data.action == ACT_PIXEL) && !in_done;

        in_col_inc = WID_W'(in_col_reg) + WID_W'(1);
        in_wrap    = in_col_inc == eff_w;
        in_row_inc = in_row_reg + ROW_W'(1);
        last_pix   = in_wrap && (in_row_inc == eff_h);
        gap_full   = gap_reg == (GAP_W'(eff_w) + GAP_W'(1));
        emit       = is_pix ? (last_pix || gap_full) : in_done;

        out_col_inc = WID_W'(out_col_reg) + WID_W'(1);
        out_wrap    = out_col_inc == eff_w;
        out_row_inc = out_row_reg + ROW_W'(1);
        frame_done  = out_wrap && (out_row_inc == eff_h);

        row_hit[0]    = in_row_inc == out_row_reg;
        row_hit[1]    = in_row_reg == out_row_reg;
        row_hit[2]    = in_row_reg == out_row_inc;
        col_hit_mid   = in_col_reg == out_col_reg;
        col_hit_right = in_col_inc == out_col_inc + WID_W'(1);

        ctl_next.top_ok    = out_row_reg != '0;
        ctl_next.bot_ok    = out_row_inc != eff_h;
        ctl_next.left_ok   = out_col_reg != '0;
        ctl_next.right_ok  = !out_wrap;
        ctl_next.border    = !(ctl_next.top_ok && ctl_next.bot_ok &&
                               ctl_next.left_ok && ctl_next.right_ok);
        ctl_next.mode      = eff_mode;
        ctl_next.frame_end = frame_done;
        ctl_next.hit_mid   = (is_pix && col_hit_mid) ? row_hit : '0;
        ctl_next.hit_right = (is_pix && col_hit_right) ? row_hit : '0;
        ctl_next.pix       = in_data.pixel_value;
        ctl_next.slot      = out_slot_reg;

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        gap_next      = gap_reg;

        if (accept)
        begin
            if (is_pix)
            begin
                in_col_next = in_wrap ? '0 : COL_W'(in_col_inc);
                if (in_wrap)
                begin
                    in_row_next  = in_row_inc;
                    in_slot_next = slot_inc(in_slot_reg);
                end
                gap_next = emit ? gap_reg : gap_reg + GAP_W'(1);
            end
            if (emit)
            begin
                out_col_next = out_wrap ? '0 : COL_W'(out_col_inc);
                if (out_wrap)
                begin
                    out_row_next  = out_row_inc;
                    out_slot_next = slot_inc(out_slot_reg);
                end
                if (frame_done)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                    gap_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg     <= WID_W'(WIDTH_START);
            act_h_reg     <= ROW_W'(HEIGHT_RST);
            act_mode_reg  <= MODE_ZERO;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            gap_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && start)
            begin
                act_w_reg    <= cfg_w_clamp;
                act_h_reg    <= cfg_h_clamp;
                act_mode_reg <= cfg_mode_clamp;
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            gap_reg      <= gap_next;

            if (accept && emit)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;

            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Line buffers, one RAM per row slot.
    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        mf3s_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk       (clk),
            .wr_en     (accept && is_pix && (in_slot_reg == slot_t'(g))),
            .wr_addr   (in_col_reg),
            .wr_data   (in_data.pixel_value),
            .rd_en     (accept && emit),
            .rd_addr_a (out_col_reg),
            .rd_addr_b (out_wrap ? '0 : COL_W'(out_col_inc)),
            .rd_data_a (rd_a[g]),
            .rd_data_b (rd_b[g])
        );
    end

    // Tap stage: the pixel of the same request replaces the stale RAM word, positions outside
    // the frame read as zero, and each column is sorted.
    always_comb
    begin
        row_slot[0] = slot_dec(s1_ctl_reg.slot);
        row_slot[1] = s1_ctl_reg.slot;
        row_slot[2] = slot_inc(s1_ctl_reg.slot);
        row_ok      = {s1_ctl_reg.bot_ok, 1'b1, s1_ctl_reg.top_ok};

        for (int k = 0; k < LINES; k++)
        begin
            if (!row_ok[k])
                mid_tap[k] = '0;
            else if (s1_ctl_reg.hit_mid[k])
                mid_tap[k] = s1_ctl_reg.pix;
            else
                mid_tap[k] = rd_a[row_slot[k]];

            if (!(row_ok[k] && s1_ctl_reg.right_ok))
                right_tap[k] = '0;
            else if (s1_ctl_reg.hit_right[k])
                right_tap[k] = s1_ctl_reg.pix;
            else
                right_tap[k] = rd_b[row_slot[k]];
        end

        left_trio  = s1_ctl_reg.left_ok ? prev_trio_reg : '0;
        mid_trio   = sort3(mid_tap[0], mid_tap[1], mid_tap[2]);
        right_trio = sort3(right_tap[0], right_tap[1], right_tap[2]);
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            s1_ctl_reg <= ctl_next;
        if (s1_move)
        begin
            prev_trio_reg  <= mid_trio;
            s2_trio_reg    <= {right_trio, mid_trio, left_trio};
            s2_center_reg  <= mid_tap[1];
            s2_border_reg  <= s1_ctl_reg.border;
            s2_mode_reg    <= s1_ctl_reg.mode;
            s2_end_reg     <= s1_ctl_reg.frame_end;
        end
        if (out_free && s2_valid_reg)
        begin
            out_data_reg.median_value <= result;
            out_data_reg.frame_end    <= s2_end_reg;
        end
    end

    // With each column sorted, the median of nine is the median of the largest low value,
    // the middle of the middle values and the smallest high value.
    always_comb
    begin
        median = med3(max3(s2_trio_reg[0].lo, s2_trio_reg[1].lo, s2_trio_reg[2].lo),
                      med3(s2_trio_reg[0].mi, s2_trio_reg[1].mi, s2_trio_reg[2].mi),
                      min3(s2_trio_reg[0].hi, s2_trio_reg[1].hi, s2_trio_reg[2].hi));
        case (s2_mode_reg)
            MODE_PAD:  result = median;
            MODE_COPY: result = s2_border_reg ? s2_center_reg : median;
            default:   result = s2_border_reg ? '0 : median;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled although the result register is empty");

    a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_ctl_reg))
        else $error("tap stage lost or changed a waiting request");

    a_rows_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg < act_h_reg && in_row_reg <= act_h_reg)
        else $error("row counter beyond the frame height");

    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg <= GAP_W'(act_w_reg) + GAP_W'(1))
        else $error("output lags input by more than one row and one pixel");

endmodule

// ----- dv/median_stream_checker.sv -----
module median_stream_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  mf3s_pkg::pix_in_t                  in_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  mf3s_pkg::pix_out_t                 out_data,
    input  logic                               cfg_write,
    input  logic [mf3s_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3s_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 fail_count,
    output int                                 pending_count,
    output int                                 checked_count
);

    import mf3s_pkg::*;

    localparam int TAPS = 9;

    logic [CFG_W_W-1:0] set_width;
    logic [CFG_H_W-1:0] set_height;
    logic [MODE_W-1:0]  set_mode;

    int    frame_w;
    int    frame_h;
    mode_t frame_mode;

    pix_t line_mem [LINES][MAX_WIDTH_DEF];
    int   rx_col;
    int   rx_row;
    int   tx_col;
    int   tx_row;

    pix_out_t due_results [$];
    pix_out_t want;
    int       mismatches;
    int       compared;

    function automatic pix_t window_tap(input int r, input int c, input bit use_new,
                                        input int new_idx, input pix_t new_val);
        int idx;
        if (r < 0 || c < 0 || r >= frame_h || c >= frame_w)
        begin
            return '0;
        end
        idx = r * frame_w + c;
        if (use_new && idx == new_idx)
        begin
            return new_val;
        end
        return line_mem[r % LINES][c % MAX_WIDTH_DEF];
    endfunction

    task automatic produce_median(input bit use_new, input int new_idx, input pix_t new_val);
        pix_t     taps [TAPS];
        int       k;
        int       below;
        int       not_above;
        bit       on_border;
        pix_out_t res;
        k = 0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                taps[k] = window_tap(tx_row + dy, tx_col + dx, use_new, new_idx, new_val);
                k++;
            end
        end
        on_border = tx_row == 0 || tx_row + 1 == frame_h || tx_col == 0 || tx_col + 1 == frame_w;
        res.median_value = '0;
        res.frame_end = 1'b0;
        if (!on_border || frame_mode == MODE_PAD)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                below = 0;
                not_above = 0;
                for (int j = 0; j < TAPS; j++)
                begin
                    if (taps[j] < taps[i])
                        below++;
                    if (taps[j] <= taps[i])
                        not_above++;
                end
                if (below <= TAPS / 2 && not_above > TAPS / 2)
                    res.median_value = taps[i];
            end
        end
        else if (frame_mode == MODE_COPY)
        begin
            res.median_value = taps[TAPS / 2];
        end
        tx_col++;
        if (tx_col >= frame_w)
        begin
            tx_col = 0;
            tx_row++;
        end
        if (tx_row >= frame_h)
        begin
            res.frame_end = 1'b1;
            rx_col = 0;
            rx_row = 0;
            tx_col = 0;
            tx_row = 0;
        end
        due_results.push_back(res);
    endtask

    task automatic filter_request(input pix_in_t req);
        int idx;
        int shown;
        int r0;
        int c0;
        if (rx_row == 0 && rx_col == 0 && tx_row == 0 && tx_col == 0)
        begin
            frame_w = (set_width == 0) ? 1 :
                      ((set_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(set_width));
            frame_h = (set_height == 0) ? 1 :
                      ((set_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(set_height));
            frame_mode = (set_mode > MODE_PAD) ? MODE_ZERO : mode_t'(set_mode);
        end
        if (req.action == ACT_PIXEL && rx_row < frame_h)
        begin
            r0 = rx_row;
            c0 = rx_col;
            idx = r0 * frame_w + c0;
            shown = tx_row * frame_w + tx_col;
            rx_col++;
            if (rx_col >= frame_w)
            begin
                rx_col = 0;
                rx_row++;
            end
            if (rx_row >= frame_h || idx + 1 - shown >= frame_w + 2)
                produce_median(1'b1, idx, req.pixel_value);
            line_mem[r0 % LINES][c0 % MAX_WIDTH_DEF] = req.pixel_value;
        end
        else if (rx_row >= frame_h)
        begin
            produce_median(1'b0, 0, '0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_width = WIDTH_RST;
            set_height = HEIGHT_RST;
            set_mode = MODE_ZERO;
            frame_w = int'(WIDTH_RST);
            frame_h = int'(HEIGHT_RST);
            frame_mode = MODE_ZERO;
            rx_col = 0;
            rx_row = 0;
            tx_col = 0;
            tx_row = 0;
            for (int a = 0; a < LINES; a++)
            begin
                for (int b = 0; b < MAX_WIDTH_DEF; b++)
                    line_mem[a][b] = '0;
            end
            due_results.delete();
            mismatches = 0;
            compared = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WIDTH:  set_width = cfg_data[CFG_W_W-1:0];
                    CFG_HEIGHT: set_height = cfg_data[CFG_H_W-1:0];
                    CFG_MODE:   set_mode = cfg_data[MODE_W-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
                filter_request(in_data);
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, median_value %0d frame_end %0b",
                             $time, out_data.median_value, out_data.frame_end);
                end
                else
                begin
                    want = due_results.pop_front();
                    compared++;
                    if (out_data.median_value !== want.median_value)
                    begin
                        mismatches++;
                        $display("%0t: median_value expected %0d, got %0d",
                                 $time, want.median_value, out_data.median_value);
                    end
                    if (out_data.frame_end !== want.frame_end)
                    begin
                        mismatches++;
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $time, want.frame_end, out_data.frame_end);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending_count <= due_results.size();
        checked_count <= compared;
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;

    import mf3s_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PIXEL_TARGET = 850;
    localparam logic ACT_FLUSH = 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    pix_out_t              out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;

    int unsigned cycle_count = 0;
    int eff_w;
    int eff_h;
    int setups = 0;
    int frames_sent = 0;
    int frame_pixels = 0;
    int pixel_requests = 0;
    int flush_requests = 0;
    bit steady_input = 1'b0;
    bit steady_output = 1'b0;

    median_filter_3x3_stream uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    median_stream_checker watcher (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int hold;
        int served;
        out_stall = 1'b0;
        served = 0;
        @(posedge rst_n);
        forever
        begin
            if (served % 40 == 0)
                steady_output = ($urandom_range(0, 3) == 0);
            hold = steady_output ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            served++;
        end
    end

    function automatic pix_t draw_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return pix_t'($urandom_range(100, 103));
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_request(input logic act, input pix_t value);
        int gap;
        gap = steady_input ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {act, value};
        do @(posedge clk); while (in_stall);
        if (act == ACT_PIXEL)
            pixel_requests++;
        else
            flush_requests++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input logic [MODE_W-1:0] mode);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= CFG_MODE;
        cfg_data <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_write <= 1'b0;
        eff_w = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
        eff_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        setups++;
    endtask

    task automatic stream_frame();
        int total;
        int drains;
        total = eff_w * eff_h;
        drains = (total - 1 < eff_w + 1) ? total - 1 : eff_w + 1;
        steady_input = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_FLUSH, draw_pixel());
            send_request(ACT_PIXEL, draw_pixel());
            frame_pixels++;
        end
        // Once the frame is in, a pixel request drains a result just like a flush.
        for (int i = 0; i < drains; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(ACT_PIXEL, draw_pixel());
            else
                send_request(ACT_FLUSH, draw_pixel());
        end
        if ($urandom_range(0, 7) == 0)
            send_request(ACT_FLUSH, draw_pixel());
        frames_sent++;
    endtask

    task automatic run_setup(input int w, input int h, input logic [MODE_W-1:0] mode,
                             input int frames);
        settle();
        configure(w, h, mode);
        repeat (frames) stream_frame();
    endtask

    initial
    begin
        int start_pixels;
        int w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width and height are written, so the border rule keeps its reset value.
        cfg_write <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= CFG_DATA_W'(4);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= CFG_DATA_W'(3);
        @(posedge clk);
        cfg_write <= 1'b0;
        eff_w = 4;
        eff_h = 3;
        setups++;
        stream_frame();

        settle();
        configure(4, 4, MODE_COPY);
        steady_input = 1'b0;
        send_request(ACT_FLUSH, 8'hFF);
        for (int i = 0; i < 16; i++)
        begin
            if (i == 6)
                send_request(ACT_FLUSH, 8'h00);
            case (i % 4)
                0:       send_request(ACT_PIXEL, 8'h00);
                1:       send_request(ACT_PIXEL, 8'hFF);
                default: send_request(ACT_PIXEL, pix_t'(i * 29 + 3));
            endcase
        end
        for (int i = 0; i < 5; i++)
            send_request(i[0] ? ACT_PIXEL : ACT_FLUSH, 8'hA5);
        send_request(ACT_FLUSH, 8'h5A);
        frames_sent++;

        run_setup(0, 5, MODE_UNUSED, 1);
        run_setup(2, 0, MODE_ZERO, 3);
        run_setup(0, 0, MODE_PAD, 3);

        start_pixels = frame_pixels;
        while (frame_pixels - start_pixels < PIXEL_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       w = $urandom_range(1, 3);
                3:       w = $urandom_range(17, 48);
                default: w = $urandom_range(4, 16);
            endcase
            run_setup(w, $urandom_range(0, 8), logic'($urandom_range(0, 3)) ?
                      MODE_W'($urandom_range(0, 3)) : MODE_PAD, $urandom_range(1, 3));
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (10) @(posedge clk);
        $display("Ran %0d frames over %0d frame setups: %0d pixel and %0d flush requests.",
                 frames_sent, setups, pixel_requests, flush_requests);
        $display("Compared %0d results, with zero sizes, tiny frames and every border rule.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
